[hdl/rspd_pkg.sv]
// rspd_pkg: shared types, character codes and helpers for the rsp packet deframer.
// Used by the event channel interface, the deframer top level, its checker and the bench.
// No dependencies.
package rspd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 1024;
    localparam int unsigned FRAME_LEN_W     = 11;

    // link characters
    localparam logic [7:0] CHAR_BREAK  = 8'h03;
    localparam logic [7:0] CHAR_START  = 8'h24;  // '$'
    localparam logic [7:0] CHAR_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CHAR_ESC    = 8'h7D;  // '}'
    localparam logic [7:0] CHAR_ABORT  = 8'hFF;
    localparam logic [7:0] CHAR_ACK    = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_NAK    = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CHAR_A_LOW  = 8'h61;  // 'a'
    localparam logic [7:0] ESC_XOR     = 8'h20;

    // event kinds on the result channel
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_BREAK = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_CHK1,
        MODE_CHK2
    } mode_t;

    // lowercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        if (nib < 4'd10)
        begin
            return CHAR_ZERO + wide;
        end
        return CHAR_A_LOW + wide - 8'd10;
    endfunction

endpackage

[hdl/rspd_byte_if.sv]
// rspd_byte_if: valid/ready channel carrying one received link byte per request.
// Depends on nothing; used by rsp_packet_deframer_unit.
interface rspd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/rspd_event_if.sv]
// rspd_event_if: valid/ready channel carrying one deframer event per request.
// Depends on rspd_pkg for the frame length width.
interface rspd_event_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       event_kind;
    logic [7:0]                       data_byte;
    logic                             frame_good;
    logic [rspd_pkg::FRAME_LEN_W-1:0] frame_length;
    logic                             overflow_seen;

    modport source (output valid, output event_kind, output data_byte, output frame_good,
                    output frame_length, output overflow_seen, input ready);
    modport sink   (input valid, input event_kind, input data_byte, input frame_good,
                    input frame_length, input overflow_seen, output ready);
endinterface

[hdl/rsp_packet_deframer_unit.sv]
// rsp_packet_deframer_unit: receive-side deframer for the debugger serial protocol.
// Depends on rspd_pkg, rspd_byte_if and rspd_event_if.
//
// Usage:
//   rx carries one link byte per request. ev carries at most one event per byte:
//   a payload byte (escapes already undone), a frame end with ack character,
//   good flag, kept length and overflow flag, or a break request.
//   Bytes outside a frame other than break and '$' are dropped silently; 0xff
//   aborts any frame in progress without an event.
// Path: a byte is captured in the input register, decoded from there and its
//   event is registered in the result register that drives ev.
// Throughput: one byte per cycle unless ev stalls; the decode is a single pass
//   of the mode register, running sum and kept count between the input and
//   result registers.
// Reset: rst_n clears both valid flags and all parse state; the block starts
//   idle, waiting for '$'.
// Stall: while ev holds an event that is not taken, the decode stage waits and
//   rx.ready drops once the input register is full; nothing is lost.
module rsp_packet_deframer_unit #(
    parameter int unsigned MAX_PAYLOAD = rspd_pkg::MAX_PAYLOAD_DEF
) (
    input logic           clk,
    input logic           rst_n,
    rspd_byte_if.sink     rx,
    rspd_event_if.source  ev
);
    import rspd_pkg::*;

    localparam int unsigned    CNT_W   = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parse state
    mode_t            mode_reg, mode_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       chk1_reg, chk1_next;
    logic             drop_reg, drop_next;

    // result register
    logic                   out_valid_reg;
    logic [1:0]             out_kind_reg;
    logic [7:0]             out_data_reg;
    logic                   out_good_reg;
    logic [FRAME_LEN_W-1:0] out_len_reg;
    logic                   out_ovf_reg;

    logic                   can_load;
    logic                   advance;
    logic                   has_room;
    logic                   sum_match;
    logic                   res_valid;
    logic [1:0]             res_kind;
    logic [7:0]             res_data;
    logic                   res_good;
    logic [FRAME_LEN_W-1:0] res_len;
    logic                   res_ovf;

    assign can_load  = !out_valid_reg || ev.ready;
    assign advance   = in_valid_reg && can_load;
    assign rx.ready  = !in_valid_reg || advance;
    assign has_room  = cnt_reg < CNT_MAX;
    assign sum_match = (chk1_reg == hex_digit(sum_reg[7:4]))
                    && (in_byte_reg == hex_digit(sum_reg[3:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (in_byte_reg == CHAR_ABORT)
        begin
            mode_next = MODE_IDLE;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (in_byte_reg == CHAR_START)
                    begin
                        mode_next = MODE_BODY;
                    end
                end
                MODE_BODY:
                begin
                    if (in_byte_reg == CHAR_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (in_byte_reg == CHAR_HASH)
                    begin
                        mode_next = MODE_CHK1;
                    end
                end
                MODE_ESC:  mode_next = MODE_BODY;
                MODE_CHK1: mode_next = MODE_CHK2;
                MODE_CHK2: mode_next = MODE_IDLE;
                default:   mode_next = MODE_IDLE;
            endcase
        end
    end

    // datapath updates and result
    always_comb
    begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        chk1_next = chk1_reg;
        drop_next = drop_reg;
        res_valid = 1'b0;
        res_kind  = KIND_DATA;
        res_data  = in_byte_reg;
        res_good  = 1'b0;
        res_len   = '0;
        res_ovf   = 1'b0;
        if (in_byte_reg != CHAR_ABORT)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (in_byte_reg == CHAR_BREAK)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_BREAK;
                    end
                    else if (in_byte_reg == CHAR_START)
                    begin
                        sum_next  = '0;
                        cnt_next  = '0;
                        drop_next = 1'b0;
                    end
                end
                MODE_BODY:
                begin
                    if (in_byte_reg == CHAR_ESC)
                    begin
                        sum_next = sum_reg + in_byte_reg;
                    end
                    else if (in_byte_reg != CHAR_HASH)
                    begin
                        if (has_room)
                        begin
                            sum_next  = sum_reg + in_byte_reg;
                            cnt_next  = cnt_reg + 1'b1;
                            res_valid = 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                end
                MODE_ESC:
                begin
                    // escaped bytes count toward the sum even when dropped
                    sum_next = sum_reg + in_byte_reg;
                    if (has_room)
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        res_valid = 1'b1;
                        res_data  = in_byte_reg ^ ESC_XOR;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                MODE_CHK1:
                begin
                    chk1_next = in_byte_reg;
                end
                MODE_CHK2:
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_END;
                    res_data  = sum_match ? CHAR_ACK : CHAR_NAK;
                    res_good  = sum_match;
                    res_len   = FRAME_LEN_W'(cnt_reg);
                    res_ovf   = drop_reg;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            chk1_reg <= '0;
            drop_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            chk1_reg <= chk1_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (ev.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
            out_good_reg <= res_good;
            out_len_reg  <= res_len;
            out_ovf_reg  <= res_ovf;
        end
    end

    assign ev.valid         = out_valid_reg;
    assign ev.event_kind    = out_kind_reg;
    assign ev.data_byte     = out_data_reg;
    assign ev.frame_good    = out_good_reg;
    assign ev.frame_length  = out_len_reg;
    assign ev.overflow_seen = out_ovf_reg;

endmodule

[hdl/rspd_checker.sv]
// rspd_checker: port-level assertions for rsp_packet_deframer_unit, plus its bind.
// Depends on rspd_pkg; attaches to the deframer top level.
module rspd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             ev_valid,
    input logic                             ev_ready,
    input logic [1:0]                       event_kind,
    input logic [7:0]                       data_byte,
    input logic                             frame_good,
    input logic [rspd_pkg::FRAME_LEN_W-1:0] frame_length,
    input logic                             overflow_seen
);
    import rspd_pkg::*;

    // a stalled event stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(data_byte) && $stable(event_kind))
        else $error("event changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (event_kind == KIND_DATA || event_kind == KIND_END
                      || event_kind == KIND_BREAK))
        else $error("unknown event kind");

    // ack character agrees with the checksum verdict
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind == KIND_END |->
            (frame_good && data_byte == CHAR_ACK) || (!frame_good && data_byte == CHAR_NAK))
        else $error("ack does not match good flag");

    // only frame ends carry status
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind != KIND_END |->
            !frame_good && !overflow_seen && frame_length == '0)
        else $error("status on non frame-end event");

    a_break: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind == KIND_BREAK |-> data_byte == CHAR_BREAK)
        else $error("break event with wrong byte");

endmodule

bind rsp_packet_deframer_unit rspd_checker u_rspd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_valid      (ev.valid),
    .ev_ready      (ev.ready),
    .event_kind    (ev.event_kind),
    .data_byte     (ev.data_byte),
    .frame_good    (ev.frame_good),
    .frame_length  (ev.frame_length),
    .overflow_seen (ev.overflow_seen)
);

[tb/rspd_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// rspd_scoreboard_pkg: event record and scoreboard for the rsp packet deframer bench.
// The scoreboard keeps its own copy of the parse state and predicts at most one event per byte.
// Depends on rspd_pkg for character codes, event kinds and parse modes.
package rspd_scoreboard_pkg;
    import rspd_pkg::*;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             data;
        logic                   good;
        logic [FRAME_LEN_W-1:0] length;
        logic                   ovf;
    } deframe_event_t;

    // lowercase hex character of a nibble
    function automatic logic [7:0] nibble_to_hex(input logic [3:0] nib);
        string digits;
        digits = "0123456789abcdef";
        return digits[nib];
    endfunction

    class deframer_scoreboard;
        mode_t            mode;
        logic [7:0]       run_sum;
        int unsigned      kept;
        logic [7:0]       first_char;
        bit               dropped;
        int unsigned      capacity;
        deframe_event_t   expected_events[$];
        int unsigned      errors;

        function new(input int unsigned cap);
            capacity   = cap;
            mode       = MODE_IDLE;
            run_sum    = '0;
            kept       = 0;
            first_char = '0;
            dropped    = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        function void expect_event(input logic [1:0] kind, input logic [7:0] data,
                                   input logic good, input int unsigned length,
                                   input logic ovf);
            deframe_event_t ev;
            ev.kind   = kind;
            ev.data   = data;
            ev.good   = good;
            ev.length = FRAME_LEN_W'(length);
            ev.ovf    = ovf;
            expected_events.push_back(ev);
        endfunction

        // advance the parse state by one accepted byte
        function void note_byte(input logic [7:0] b);
            logic good;
            if (b == CHAR_ABORT)
            begin
                mode = MODE_IDLE;
                return;
            end
            case (mode)
                MODE_IDLE:
                begin
                    if (b == CHAR_BREAK)
                    begin
                        expect_event(KIND_BREAK, CHAR_BREAK, 1'b0, 0, 1'b0);
                    end
                    else if (b == CHAR_START)
                    begin
                        run_sum = '0;
                        kept    = 0;
                        dropped = 1'b0;
                        mode    = MODE_BODY;
                    end
                end
                MODE_BODY:
                begin
                    if (b == CHAR_ESC)
                    begin
                        run_sum = run_sum + b;
                        mode    = MODE_ESC;
                    end
                    else if (b == CHAR_HASH)
                    begin
                        mode = MODE_CHK1;
                    end
                    else if (kept < capacity)
                    begin
                        run_sum = run_sum + b;
                        kept++;
                        expect_event(KIND_DATA, b, 1'b0, 0, 1'b0);
                    end
                    else
                    begin
                        dropped = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    // escaped byte is summed even when it no longer fits
                    run_sum = run_sum + b;
                    mode    = MODE_BODY;
                    if (kept < capacity)
                    begin
                        kept++;
                        expect_event(KIND_DATA, b ^ ESC_XOR, 1'b0, 0, 1'b0);
                    end
                    else
                    begin
                        dropped = 1'b1;
                    end
                end
                MODE_CHK1:
                begin
                    first_char = b;
                    mode       = MODE_CHK2;
                end
                MODE_CHK2:
                begin
                    good = (first_char == nibble_to_hex(run_sum[7:4])) &&
                           (b == nibble_to_hex(run_sum[3:0]));
                    mode = MODE_IDLE;
                    expect_event(KIND_END, good ? CHAR_ACK : CHAR_NAK, good, kept, dropped);
                end
                default:
                begin
                    mode = MODE_IDLE;
                end
            endcase
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_event(input deframe_event_t got);
            deframe_event_t want;
            if (expected_events.size() == 0)
            begin
                report($sformatf("unexpected event kind %0d data %02h", got.kind, got.data));
                return;
            end
            want = expected_events.pop_front();
            if (got.kind !== want.kind)
            begin
                report($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
            end
            if (got.data !== want.data)
            begin
                report($sformatf("data_byte %02h, want %02h", got.data, want.data));
            end
            if (got.good !== want.good)
            begin
                report($sformatf("frame_good %0b, want %0b", got.good, want.good));
            end
            if (got.length !== want.length)
            begin
                report($sformatf("frame_length %0d, want %0d", got.length, want.length));
            end
            if (got.ovf !== want.ovf)
            begin
                report($sformatf("overflow_seen %0b, want %0b", got.ovf, want.ovf));
            end
        endtask
    endclass

endpackage

[tb/rsp_packet_deframer_unit_tb.sv]
`timescale 1ns / 100ps
// rsp_packet_deframer_unit_tb: drives link bytes into the deframer and checks every event.
// Directed frames first, then random frames, breaks, noise and aborts with random stalls.
// Depends on rspd_pkg, rspd_scoreboard_pkg, both channel interfaces and the deframer.
module rsp_packet_deframer_unit_tb;
    import rspd_pkg::*;
    import rspd_scoreboard_pkg::*;

    localparam int unsigned CAPACITY     = MAX_PAYLOAD_DEF;
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned IDLE_PCT     = 38;
    localparam logic [7:0]  CASE_BIT     = 8'h20;

    typedef logic [7:0] byte_q_t[$];
    typedef enum int unsigned {TRAIL_GOOD, TRAIL_BAD, TRAIL_UPPER, TRAIL_ABORT} trail_t;

    logic clk = 1'b0;
    logic rst_n;

    rspd_byte_if  rx_if ();
    rspd_event_if ev_if ();

    rsp_packet_deframer_unit #(.MAX_PAYLOAD(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .ev    (ev_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    deframer_scoreboard sb;
    bit          rx_steady;
    bit          ev_steady;
    int unsigned hold_req;
    int unsigned bytes_sent;
    int unsigned noise_sent;

    function automatic bit rx_gap();
        return !rx_steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic bit ev_gap();
        return !ev_steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // called at a falling edge, returns at the falling edge after the request
    task automatic send_byte(input logic [7:0] b);
        while (rx_gap())
        begin
            rx_if.valid <= 1'b0;
            @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // payload tokens, escape pairs at esc_pct percent; never '#' or abort unescaped
    function automatic byte_q_t random_body(input int unsigned tokens,
                                            input int unsigned esc_pct);
        byte_q_t    q;
        logic [7:0] b;
        repeat (tokens)
        begin
            if ($urandom_range(99) < esc_pct)
            begin
                b = 8'($urandom_range(254));
                q.push_back(CHAR_ESC);
                q.push_back(b);
            end
            else
            begin
                do
                begin
                    b = 8'($urandom_range(254));
                end
                while (b == CHAR_ESC || b == CHAR_HASH);
                q.push_back(b);
            end
        end
        return q;
    endfunction

    task automatic send_frame(input byte_q_t body, input trail_t trail);
        logic [7:0]  cks;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  right_lo;
        int unsigned kept;
        bit          esc;
        cks  = '0;
        kept = 0;
        esc  = 1'b0;
        // plain bytes past capacity are left out of the sum, escaped ones are not
        foreach (body[i])
        begin
            if (esc)
            begin
                cks = cks + body[i];
                esc = 1'b0;
                if (kept < CAPACITY)
                begin
                    kept++;
                end
            end
            else if (body[i] == CHAR_ESC)
            begin
                cks = cks + body[i];
                esc = 1'b1;
            end
            else if (kept < CAPACITY)
            begin
                cks = cks + body[i];
                kept++;
            end
        end
        hi       = nibble_to_hex(cks[7:4]);
        right_lo = nibble_to_hex(cks[3:0]);
        lo       = right_lo;
        case (trail)
            TRAIL_BAD:
            begin
                do
                begin
                    lo = 8'($urandom_range(254));
                end
                while (lo == right_lo);
            end
            TRAIL_UPPER:
            begin
                if (hi >= CHAR_A_LOW)
                begin
                    hi = hi ^ CASE_BIT;
                end
                if (lo >= CHAR_A_LOW)
                begin
                    lo = lo ^ CASE_BIT;
                end
            end
            TRAIL_ABORT:
            begin
                lo = CHAR_ABORT;
            end
            default:
            begin
            end
        endcase
        send_byte(CHAR_START);
        foreach (body[i])
        begin
            send_byte(body[i]);
        end
        send_byte(CHAR_HASH);
        send_byte(hi);
        send_byte(lo);
    endtask

    task automatic send_broken(input byte_q_t body);
        send_byte(CHAR_START);
        foreach (body[i])
        begin
            send_byte(body[i]);
        end
        send_byte(CHAR_ABORT);
    endtask

    // event side: sample at the rising edge, decide ready at the falling edge
    initial
    begin : event_sink
        int unsigned    hold_left;
        deframe_event_t got;
        hold_left   = 0;
        ev_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (ev_if.valid && ev_if.ready)
            begin
                got.kind   = ev_if.event_kind;
                got.data   = ev_if.data_byte;
                got.good   = ev_if.frame_good;
                got.length = ev_if.frame_length;
                got.ovf    = ev_if.overflow_seen;
                sb.check_event(got);
            end
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                ev_if.ready <= 1'b0;
            end
            else
            begin
                ev_if.ready <= !ev_gap();
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        byte_q_t     body;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned random_start;
        int unsigned steady_mark;
        bit          big_done;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        rx_steady     = 1'b0;
        ev_steady     = 1'b0;
        hold_req      = 0;
        bytes_sent    = 0;
        noise_sent    = 0;
        steady_mark   = 0;
        big_done      = 1'b0;
        sb            = new(CAPACITY);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle noise, break, then frames covering escapes and byte extremes
        send_byte(8'h41);
        send_byte(CHAR_BREAK);
        body = {8'h00, CHAR_ESC, CHAR_BREAK};
        send_frame(body, TRAIL_GOOD);
        // start and break characters inside a frame are plain payload
        body = {8'hFE, CHAR_START, CHAR_BREAK};
        send_frame(body, TRAIL_BAD);
        body = {CHAR_ESC, 8'h5D};
        send_frame(body, TRAIL_UPPER);
        body = {8'h71};
        send_broken(body);
        body = {CHAR_ESC};
        send_broken(body);
        body = {};
        send_frame(body, TRAIL_ABORT);
        send_frame(body, TRAIL_GOOD);

        random_start = bytes_sent - noise_sent;
        while (bytes_sent - noise_sent - random_start < RANDOM_ITEMS)
        begin
            if (steady_mark != 0 && bytes_sent > steady_mark)
            begin
                rx_steady   = 1'b0;
                ev_steady   = 1'b0;
                steady_mark = 0;
            end
            pick = $urandom_range(99);
            if (!big_done && bytes_sent - noise_sent - random_start > 300)
            begin
                // fill to capacity, then drop plain bytes and an escaped byte
                body = random_body(CAPACITY - 2, 0);
                b = 8'($urandom_range(254));
                body.push_back(CHAR_ESC);
                body.push_back(b);
                body = {body, random_body(2, 0)};
                b = 8'($urandom_range(254));
                body.push_back(CHAR_ESC);
                body.push_back(b);
                body = {body, random_body(1, 0)};
                // receiver holds off while the sender keeps pushing
                rx_steady = 1'b1;
                hold_req  = 250;
                send_frame(body, TRAIL_GOOD);
                big_done    = 1'b1;
                ev_steady   = 1'b1;
                steady_mark = bytes_sent + 200;
            end
            else if (pick < 6)
            begin
                send_byte(CHAR_BREAK);
            end
            else if (pick < 12)
            begin
                b = 8'($urandom_range(255));
                if (b == CHAR_START)
                begin
                    b = 8'h00;
                end
                send_byte(b);
                if (b != CHAR_BREAK)
                begin
                    noise_sent++;
                end
            end
            else if (pick < 20)
            begin
                body = random_body($urandom_range(0, 8), 20);
                if ($urandom_range(1) == 1)
                begin
                    body.push_back(CHAR_ESC);
                end
                send_broken(body);
            end
            else if (pick < 24)
            begin
                body = random_body($urandom_range(0, 8), 20);
                send_frame(body, TRAIL_ABORT);
            end
            else
            begin
                body = random_body($urandom_range(0, 12), 20);
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    send_frame(body, TRAIL_GOOD);
                end
                else if (pick < 85)
                begin
                    send_frame(body, TRAIL_BAD);
                end
                else
                begin
                    send_frame(body, TRAIL_UPPER);
                end
            end
        end
        rx_if.valid <= 1'b0;
        rx_steady   = 1'b0;
        ev_steady   = 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
